// ===== hw/rtl/rgb565_hls_color_classifier_top_assert.svh =====
// Assertion macros for the color classifier.
// Each macro takes a label, the clock, the active-low reset, the property terms
// and a message.
`ifndef RGB565_HLS_COLOR_CLASSIFIER_TOP_ASSERT_SVH
`define RGB565_HLS_COLOR_CLASSIFIER_TOP_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define RHCC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RHCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RHCC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define RHCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/rhcc_pkg.sv =====
package rhcc_pkg;

    // field widths
    localparam int PIXEL_W    = 16;
    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HUE_MIN   = 3'd0,
        REG_HUE_MAX   = 3'd1,
        REG_SAT_MIN   = 3'd2,
        REG_SAT_MAX   = 3'd3,
        REG_LIGHT_MIN = 3'd4,
        REG_LIGHT_MAX = 3'd5
    } cfg_idx_t;

    // configuration reset values
    localparam logic [CFG_DATA_W-1:0] HUE_MIN_RST   = 8'd0;
    localparam logic [CFG_DATA_W-1:0] HUE_MAX_RST   = 8'd240;
    localparam logic [CFG_DATA_W-1:0] SAT_MIN_RST   = 8'd0;
    localparam logic [CFG_DATA_W-1:0] SAT_MAX_RST   = 8'd240;
    localparam logic [CFG_DATA_W-1:0] LIGHT_MIN_RST = 8'd120;
    localparam logic [CFG_DATA_W-1:0] LIGHT_MAX_RST = 8'd240;

endpackage

// ===== hw/rtl/rhcc_pixel_if.sv =====
interface rhcc_pixel_if import rhcc_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_rgb565;

    modport source (output valid, output pixel_rgb565, input ready);
    modport sink   (input valid, input pixel_rgb565, output ready);

endinterface

// ===== hw/rtl/rhcc_result_if.sv =====
interface rhcc_result_if import rhcc_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              is_match;
    logic [CHAN_W-1:0] hue;
    logic [CHAN_W-1:0] lightness;
    logic [CHAN_W-1:0] saturation;

    modport source (output valid, output is_match, output hue, output lightness,
                    output saturation, input ready);
    modport sink   (input valid, input is_match, input hue, input lightness,
                    input saturation, output ready);

endinterface

// ===== hw/rtl/rgb565_hls_color_classifier_top.sv =====
// RGB565 color classifier: each accepted pixel is widened to 8-bit channels,
// converted to hue, lightness and saturation on a 0..240 scale and tested
// against the six configured exclusive bounds; one result comes out per pixel,
// in order. The block takes one pixel per clock unless every stage is full and
// the output is stalled. The datapath is an 8-stage pipeline: channel min/max and
// hue sector, constant multiplies for the dividends and lightness, saturation
// divisor select, four divider stages of two quotient bits each (hue and
// saturation in parallel), then the threshold compare into the output register.
// Every stage holds its transaction under backpressure and empty stages fill,
// so pixels keep being taken while a result waits at the output as long as
// a stage is free. Write the bounds only while no transaction is in flight.

`include "rgb565_hls_color_classifier_top_assert.svh"

module rgb565_hls_color_classifier_top import rhcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rhcc_pixel_if.sink            pixel,
    rhcc_result_if.source         result
);

    localparam int NSTAGE     = 8;
    localparam int LAST       = NSTAGE - 1;
    localparam int DIV_STAGES = 4;
    localparam int DIV_FIRST  = 3;
    localparam int DIV_STEPS  = 2;
    localparam int Q_W        = DIV_STAGES * DIV_STEPS;

    // hue sector bases and scales
    localparam logic [CHAN_W-1:0] HUE_BASE_RB = 8'd0;
    localparam logic [CHAN_W-1:0] HUE_BASE_RG = 8'd240;
    localparam logic [CHAN_W-1:0] HUE_BASE_G  = 8'd80;
    localparam logic [CHAN_W-1:0] HUE_BASE_B  = 8'd160;
    localparam int HUE_SECTOR  = 40;
    localparam int SAT_SCALE   = 240;
    localparam logic [CHAN_W-1:0] LIGHT_HALF = 8'd120;
    localparam logic [8:0] SUM_FULL = 9'd510;
    // lightness = floor(sum * 8 / 17) = (sum * 7711) >> 14 for sum <= 510
    localparam int LIGHT_RECIP = 7711;
    localparam int LIGHT_SHIFT = 14;
    localparam int LMUL_W      = 22;

    typedef enum logic [1:0] {
        SECT_RB,
        SECT_RG,
        SECT_G,
        SECT_B
    } hue_sect_t;

    typedef struct packed {
        logic              grey;
        logic              neg;
        logic [CHAN_W-1:0] base;
        logic [CHAN_W-1:0] mag;
        logic [CHAN_W-1:0] dif;
        logic [8:0]        sum;
    } hsl0_t;

    typedef struct packed {
        logic              grey;
        logic              neg;
        logic [CHAN_W-1:0] base;
        logic [15:0]       hnum;
        logic [CHAN_W-1:0] hden;
        logic [15:0]       snum;
        logic [8:0]        sum;
        logic [CHAN_W-1:0] light;
    } hsl1_t;

    typedef struct packed {
        logic              grey;
        logic              s_zero;
        logic              neg;
        logic [CHAN_W-1:0] base;
        logic [CHAN_W-1:0] light;
        logic [15:0]       hrem;
        logic [CHAN_W-1:0] hden;
        logic [Q_W-1:0]    hq;
        logic [15:0]       srem;
        logic [8:0]        sden;
        logic [Q_W-1:0]    sq;
    } div_t;

    // configuration registers
    logic [CFG_DATA_W-1:0] hue_min_reg;
    logic [CFG_DATA_W-1:0] hue_max_reg;
    logic [CFG_DATA_W-1:0] sat_min_reg;
    logic [CFG_DATA_W-1:0] sat_max_reg;
    logic [CFG_DATA_W-1:0] light_min_reg;
    logic [CFG_DATA_W-1:0] light_max_reg;

    // pipeline control
    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] move;

    // pipeline payload
    hsl0_t s0_reg;
    hsl0_t s0_next;
    hsl1_t s1_reg;
    hsl1_t s1_next;
    div_t  div_reg  [DIV_STAGES+1];
    div_t  div_next [DIV_STAGES+1];

    logic              out_match_reg;
    logic [CHAN_W-1:0] out_hue_reg;
    logic [CHAN_W-1:0] out_light_reg;
    logic [CHAN_W-1:0] out_sat_reg;
    logic              out_match_next;
    logic [CHAN_W-1:0] out_hue_next;
    logic [CHAN_W-1:0] out_sat_next;

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_min_reg   <= HUE_MIN_RST;
            hue_max_reg   <= HUE_MAX_RST;
            sat_min_reg   <= SAT_MIN_RST;
            sat_max_reg   <= SAT_MAX_RST;
            light_min_reg <= LIGHT_MIN_RST;
            light_max_reg <= LIGHT_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HUE_MIN:   hue_min_reg   <= cfg_data;
                REG_HUE_MAX:   hue_max_reg   <= cfg_data;
                REG_SAT_MIN:   sat_min_reg   <= cfg_data;
                REG_SAT_MAX:   sat_max_reg   <= cfg_data;
                REG_LIGHT_MIN: light_min_reg <= cfg_data;
                REG_LIGHT_MAX: light_max_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // a stage moves when it is empty or its successor moves
    always_comb
    begin
        move[LAST] = !v_reg[LAST] || result.ready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            move[i] = !v_reg[i] || move[i+1];
        end
    end

    assign pixel.ready = move[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (move[0])
            begin
                v_reg[0] <= pixel.valid;
            end
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (move[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // stage 0: widen channels, max/min, hue sector and signed difference
    always_comb
    begin
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] mx;
        logic [CHAN_W-1:0] mn;
        logic [CHAN_W-1:0] op_a;
        logic [CHAN_W-1:0] op_c;
        hue_sect_t         sect;

        r = {pixel.pixel_rgb565[15:11], 3'b000};
        g = {pixel.pixel_rgb565[10:5], 2'b00};
        b = {pixel.pixel_rgb565[4:0], 3'b000};

        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;

        if (mx == r)
            sect = (mn == b) ? SECT_RB : SECT_RG;
        else if (mx == g)
            sect = SECT_G;
        else
            sect = SECT_B;

        case (sect)
            SECT_RB:
            begin
                op_a = g;
                op_c = b;
                s0_next.base = HUE_BASE_RB;
            end
            SECT_RG:
            begin
                op_a = g;
                op_c = b;
                s0_next.base = HUE_BASE_RG;
            end
            SECT_G:
            begin
                op_a = b;
                op_c = r;
                s0_next.base = HUE_BASE_G;
            end
            SECT_B:
            begin
                op_a = r;
                op_c = g;
                s0_next.base = HUE_BASE_B;
            end
            default:
            begin
                op_a = g;
                op_c = b;
                s0_next.base = HUE_BASE_RB;
            end
        endcase

        // truncation toward zero: divide the magnitude, apply the sign later
        s0_next.neg  = op_a < op_c;
        s0_next.mag  = s0_next.neg ? (op_c - op_a) : (op_a - op_c);
        s0_next.dif  = mx - mn;
        s0_next.sum  = 9'(mx) + 9'(mn);
        s0_next.grey = (mx == mn);
    end

    always_ff @(posedge clk)
    begin
        if (move[0])
        begin
            s0_reg <= s0_next;
        end
    end

    // stage 1: dividends and lightness
    always_comb
    begin
        logic [LMUL_W-1:0] lmul;

        lmul = LMUL_W'(s0_reg.sum) * LMUL_W'(LIGHT_RECIP);
        s1_next.grey  = s0_reg.grey;
        s1_next.neg   = s0_reg.neg;
        s1_next.base  = s0_reg.base;
        s1_next.hnum  = 16'(s0_reg.mag) * 16'(HUE_SECTOR);
        s1_next.hden  = s0_reg.dif;
        s1_next.snum  = 16'(s0_reg.dif) * 16'(SAT_SCALE);
        s1_next.sum   = s0_reg.sum;
        s1_next.light = lmul[LIGHT_SHIFT +: CHAN_W];
    end

    always_ff @(posedge clk)
    begin
        if (move[1])
        begin
            s1_reg <= s1_next;
        end
    end

    // stage 2: saturation divisor select, divider setup
    always_comb
    begin
        div_next[0].grey   = s1_reg.grey;
        div_next[0].neg    = s1_reg.neg;
        div_next[0].base   = s1_reg.base;
        div_next[0].light  = s1_reg.light;
        div_next[0].hrem   = s1_reg.hnum;
        div_next[0].hden   = s1_reg.hden;
        div_next[0].hq     = '0;
        div_next[0].srem   = s1_reg.snum;
        div_next[0].sden   = (s1_reg.light <= LIGHT_HALF) ? s1_reg.sum
                                                          : (SUM_FULL - s1_reg.sum);
        div_next[0].sq     = '0;
        // zero lightness or zero divisor gives zero saturation
        div_next[0].s_zero = s1_reg.grey || (s1_reg.light == '0) ||
                             (div_next[0].sden == '0);
    end

    always_ff @(posedge clk)
    begin
        if (move[2])
        begin
            div_reg[0] <= div_next[0];
        end
    end

    // stages 3..6: restoring division, two quotient bits per stage, MSB first
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        always_comb
        begin
            logic [16:0] trial_h;
            logic [16:0] trial_s;
            logic        take_h;
            logic        take_s;

            div_next[k+1] = div_reg[k];
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                trial_h = 17'(div_next[k+1].hden) << (Q_W - 1 - DIV_STEPS * k - j);
                trial_s = 17'(div_next[k+1].sden) << (Q_W - 1 - DIV_STEPS * k - j);
                take_h  = 17'(div_next[k+1].hrem) >= trial_h;
                take_s  = 17'(div_next[k+1].srem) >= trial_s;
                if (take_h)
                    div_next[k+1].hrem = 16'(17'(div_next[k+1].hrem) - trial_h);
                if (take_s)
                    div_next[k+1].srem = 16'(17'(div_next[k+1].srem) - trial_s);
                div_next[k+1].hq = {div_next[k+1].hq[Q_W-2:0], take_h};
                div_next[k+1].sq = {div_next[k+1].sq[Q_W-2:0], take_s};
            end
        end

        always_ff @(posedge clk)
        begin
            if (move[DIV_FIRST + k])
            begin
                div_reg[k+1] <= div_next[k+1];
            end
        end
    end

    // stage 7: apply hue sign, grey overrides, threshold compare
    always_comb
    begin
        div_t d;

        d = div_reg[DIV_STAGES];
        if (d.grey)
            out_hue_next = '0;
        else if (d.neg)
            out_hue_next = d.base - d.hq;
        else
            out_hue_next = d.base + d.hq;

        out_sat_next = d.s_zero ? '0 : d.sq;

        out_match_next = (out_hue_next > hue_min_reg) && (out_hue_next < hue_max_reg) &&
                         (d.light > light_min_reg) && (d.light < light_max_reg) &&
                         (out_sat_next > sat_min_reg) && (out_sat_next < sat_max_reg);
    end

    always_ff @(posedge clk)
    begin
        if (move[LAST])
        begin
            out_match_reg <= out_match_next;
            out_hue_reg   <= out_hue_next;
            out_light_reg <= div_reg[DIV_STAGES].light;
            out_sat_reg   <= out_sat_next;
        end
    end

    assign result.valid      = v_reg[LAST];
    assign result.is_match   = out_match_reg;
    assign result.hue        = out_hue_reg;
    assign result.lightness  = out_light_reg;
    assign result.saturation = out_sat_reg;

    // checks
    `RHCC_ASSERT_NEXT(a_accept_loads_stage0, clk, rst_n, pixel.valid && pixel.ready, v_reg[0], "accepted transaction missing from first stage")
    `RHCC_ASSERT_IMPLIES(a_hue_needs_sat, clk, rst_n, result.valid && (result.hue != 8'd0), result.saturation != 8'd0, "nonzero hue with zero saturation")
    `RHCC_ASSERT_IMPLIES(a_black_is_grey, clk, rst_n, result.valid && (result.lightness == 8'd0), (result.hue == 8'd0) && (result.saturation == 8'd0), "zero lightness pixel not grey")

endmodule

// ===== sim/rgb565_hls_color_classifier_top_tb.sv =====
`timescale 1ns / 100ps

module rgb565_hls_color_classifier_top_tb;
    import rhcc_pkg::*;

    // register indexes past the end of the bound list; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_HI = 3'd7;

    localparam int ITEMS_PER_PHASE = 250;
    localparam int NUM_PHASES      = 5;
    localparam int PIPE_LATENCY    = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 10;

    typedef struct {
        logic [PIXEL_W-1:0] pixel;
        logic               is_match;
        logic [CHAN_W-1:0]  hue;
        logic [CHAN_W-1:0]  lightness;
        logic [CHAN_W-1:0]  saturation;
    } hls_expect_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rhcc_pixel_if  pix_if ();
    rhcc_result_if res_if ();

    rgb565_hls_color_classifier_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pix_if.sink),
        .result    (res_if.source)
    );

    // local copy of the six bounds
    logic [CHAN_W-1:0] hue_lo, hue_hi, sat_lo, sat_hi, light_lo, light_hi;

    logic [PIXEL_W-1:0] pixel_q[$];
    hls_expect_t        expected_hls_q[$];

    int  pixels_pushed  = 0;
    int  results_seen   = 0;
    int  matches_seen   = 0;
    int  mismatch_count = 0;
    int  bound_writes   = 0;
    int  src_idle_pct   = 0;
    int  sink_stall_pct = 0;
    bit  hold_off       = 1'b0;
    logic pixel_taken;

    always #4 clk = ~clk;

    // HLS conversion and bound test for one pixel
    function automatic hls_expect_t predict_hls(logic [PIXEL_W-1:0] px);
        int r, g, b, mx, mn, dif, sum, h, l, s;
        hls_expect_t res;
        r   = int'({px[15:11], 3'b000});
        g   = int'({px[10:5], 2'b00});
        b   = int'({px[4:0], 3'b000});
        mx  = (r > g) ? r : g;
        mx  = (b > mx) ? b : mx;
        mn  = (r < g) ? r : g;
        mn  = (b < mn) ? b : mn;
        dif = mx - mn;
        sum = mx + mn;
        l   = sum * 240 / 255 / 2;
        h   = 0;
        s   = 0;
        if (dif != 0)
        begin
            // hue sector; red wins ties, then green
            if (mx == r)
                h = (mn == b) ? 40 * (g - b) / dif : 40 * (g - b) / dif + 240;
            else if (mx == g)
                h = 40 * (b - r) / dif + 80;
            else
                h = 40 * (r - g) / dif + 160;
            // saturation divisor depends on the lightness half
            if (l == 0)
                s = 0;
            else if (l <= 120)
                s = (sum != 0) ? dif * 240 / sum : 0;
            else
                s = (510 - sum > 0) ? dif * 240 / (510 - sum) : 0;
        end
        res.pixel      = px;
        res.hue        = h[7:0];
        res.lightness  = l[7:0];
        res.saturation = s[7:0];
        res.is_match   = (res.hue > hue_lo) && (res.hue < hue_hi) &&
                         (res.lightness > light_lo) && (res.lightness < light_hi) &&
                         (res.saturation > sat_lo) && (res.saturation < sat_hi);
        return res;
    endfunction

    // mostly uniform pixels, with greys and two-channel extremes mixed in
    function automatic logic [PIXEL_W-1:0] random_pixel();
        logic [4:0] v;
        v = 5'($urandom_range(31));
        case ($urandom_range(9))
            0: return {v, v, 1'b0, v};
            1: return {$urandom_range(1) ? 5'h1f : 5'h00, 6'($urandom_range(63)),
                       $urandom_range(1) ? 5'h1f : 5'h00};
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // pixel driver
    always @(negedge clk)
    begin
        if (!rst_n)
            pix_if.valid <= 1'b0;
        else if (!pix_if.valid || pixel_taken)
        begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                pix_if.valid        <= 1'b1;
                pix_if.pixel_rgb565 <= pixel_q.pop_front();
            end
            else
                pix_if.valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // monitor: predict on each pixel transaction, check each result transaction
    always @(posedge clk)
    begin : monitor
        hls_expect_t exp_r;
        pixel_taken <= rst_n && pix_if.valid && pix_if.ready;
        if (rst_n && pix_if.valid && pix_if.ready)
            expected_hls_q.push_back(predict_hls(pix_if.pixel_rgb565));
        if (rst_n && res_if.valid && res_if.ready)
        begin
            results_seen++;
            if (res_if.is_match)
                matches_seen++;
            if (expected_hls_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result match=%0d h=%0d l=%0d s=%0d", $time,
                             res_if.is_match, res_if.hue, res_if.lightness,
                             res_if.saturation);
            end
            else
            begin
                exp_r = expected_hls_q.pop_front();
                if (res_if.is_match !== exp_r.is_match || res_if.hue !== exp_r.hue ||
                    res_if.lightness !== exp_r.lightness ||
                    res_if.saturation !== exp_r.saturation)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: pixel %h expected m=%0d h=%0d l=%0d s=%0d, got m=%0d h=%0d l=%0d s=%0d",
                                 $time, exp_r.pixel, exp_r.is_match, exp_r.hue,
                                 exp_r.lightness, exp_r.saturation, res_if.is_match,
                                 res_if.hue, res_if.lightness, res_if.saturation);
                end
            end
        end
    end

    // one register write, mirrored into the local bounds
    task automatic write_bound(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_HUE_MIN:   hue_lo   = val;
            REG_HUE_MAX:   hue_hi   = val;
            REG_SAT_MIN:   sat_lo   = val;
            REG_SAT_MAX:   sat_hi   = val;
            REG_LIGHT_MIN: light_lo = val;
            REG_LIGHT_MAX: light_hi = val;
            default: ;
        endcase
        bound_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_pixel(logic [PIXEL_W-1:0] px);
        pixel_q.push_back(px);
        pixels_pushed++;
    endtask

    // wait for every result, then let the pipeline drain
    task automatic wait_drained();
        while (results_seen != pixels_pushed)
            @(negedge clk);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
    endtask

    // bound settings: open, closed, and random windows
    task automatic load_bounds(int setting);
        case (setting)
            0:
            begin
                write_bound(REG_HUE_MIN, 8'd0);
                write_bound(REG_HUE_MAX, 8'd255);
                write_bound(REG_SAT_MIN, 8'd0);
                write_bound(REG_SAT_MAX, 8'd255);
                write_bound(REG_LIGHT_MIN, 8'd0);
                write_bound(REG_LIGHT_MAX, 8'd255);
            end
            2:
            begin
                // min >= max everywhere: nothing can match
                write_bound(REG_HUE_MIN, 8'd255);
                write_bound(REG_HUE_MAX, 8'd0);
                write_bound(REG_SAT_MIN, 8'd240);
                write_bound(REG_SAT_MAX, 8'd240);
                write_bound(REG_LIGHT_MIN, 8'd200);
                write_bound(REG_LIGHT_MAX, 8'd100);
                write_bound(UNMAPPED_IDX_LO, 8'($urandom_range(255)));
                write_bound(UNMAPPED_IDX_HI, 8'($urandom_range(255)));
            end
            default:
            begin
                write_bound(REG_HUE_MIN, 8'($urandom_range(120)));
                write_bound(REG_HUE_MAX, 8'($urandom_range(255, 100)));
                write_bound(REG_SAT_MIN, 8'($urandom_range(100)));
                write_bound(REG_SAT_MAX, 8'($urandom_range(255, 120)));
                write_bound(REG_LIGHT_MIN, 8'($urandom_range(100)));
                write_bound(REG_LIGHT_MAX, 8'($urandom_range(255, 120)));
            end
        endcase
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        pix_if.valid        = 1'b0;
        pix_if.pixel_rgb565 = '0;
        res_if.ready        = 1'b0;
        hue_lo              = HUE_MIN_RST;
        hue_hi              = HUE_MAX_RST;
        sat_lo              = SAT_MIN_RST;
        sat_hi              = SAT_MAX_RST;
        light_lo            = LIGHT_MIN_RST;
        light_hi            = LIGHT_MAX_RST;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed pixels under the reset bounds
        push_pixel(16'h0000);   // black, grey
        push_pixel(16'hffff);   // white; green widens to 252, so not grey
        push_pixel(16'h8410);   // mid grey
        push_pixel(16'hf800);   // red
        push_pixel(16'h07e0);   // green
        push_pixel(16'h001f);   // blue
        push_pixel(16'hffe0);   // yellow: green widens to 252, above red
        push_pixel(16'h07ff);   // cyan: green widens to 252, above blue
        push_pixel(16'hf81f);   // magenta: red max, green min
        push_pixel(16'hf821);   // red max, green min, hue wraps to 240
        push_pixel(16'h0020);   // faintest green
        push_pixel(16'h0821);   // dark near-grey
        push_pixel(16'hffdf);   // light, second saturation divisor
        push_pixel(16'hfbef);   // light red
        push_pixel(16'h7bef);   // dark grey-ish
        push_pixel(16'haaaa);
        push_pixel(16'h5555);
        push_pixel(16'hf7be);
        push_pixel(16'h8000);
        push_pixel(16'h0400);
        push_pixel(16'h0010);
        wait_drained();

        // random phases, each with its own bounds and idling mode
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            load_bounds(p);
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 51; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 51; end
                default: begin src_idle_pct = 24; sink_stall_pct = 24; end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                push_pixel(random_pixel());
            // back the pipeline up once while pixels keep coming
            if (p == NUM_PHASES - 1)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (HOLD_OFF_CYCLES) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            wait_drained();
        end

        repeat (4 * PIPE_LATENCY) @(negedge clk);
        $display("Ran %0d pixels through %0d bound writes and four idling modes; %0d matched.",
                 pixels_pushed, bound_writes, matches_seen);
        $display("Output was held off %0d cycles once; %0d mismatches, %0d results pending.",
                 HOLD_OFF_CYCLES, mismatch_count, expected_hls_q.size());
        if (mismatch_count == 0 && expected_hls_q.size() == 0)
            $display("** rgb565_hls_color_classifier_top: PASSED **");
        else
            $display("** rgb565_hls_color_classifier_top: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Timeout: %0d of %0d results seen", results_seen, pixels_pushed);
        $display("** rgb565_hls_color_classifier_top: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rhcc_pkg.sv
hw/rtl/rhcc_pixel_if.sv
hw/rtl/rhcc_result_if.sv
hw/rtl/rgb565_hls_color_classifier_top.sv
sim/rgb565_hls_color_classifier_top_tb.sv
